@@ hdl/link_health_monitor_unit_assert.svh @@
// Assertion macros for the link health monitor.
`ifndef LINK_HEALTH_MONITOR_UNIT_ASSERT_SVH
`define LINK_HEALTH_MONITOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked property check, disabled while in reset.
`define LHM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen at a clock edge.
`define LHM_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LHM_ASSERT(lbl, clk, rst_n, prop, msg)
`define LHM_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ hdl/lhm_pkg.sv @@
// Shared types, codes and helpers of the link health monitor.
package lhm_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int CMP_W       = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOWN_MODE    = 2'd0,
    REG_UP_MODE      = 2'd1,
    REG_RETRY_LIMIT  = 2'd2,
    REG_UP_THRESHOLD = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DOWN_STOP    = 2'd0,
    DOWN_SUSPEND = 2'd1,
    DOWN_POST    = 2'd2,
    DOWN_RETRY   = 2'd3
  } down_mode_t;

  localparam logic UP_POST   = 1'b0;
  localparam logic UP_IGNORE = 1'b1;

  localparam logic [1:0] EVT_NONE = 2'd0;
  localparam logic [1:0] EVT_DOWN = 2'd1;
  localparam logic [1:0] EVT_UP   = 2'd2;

  typedef struct packed {
    down_mode_t down_mode;
    logic       up_mode;
    logic [7:0] retry_limit;
    logic [7:0] up_threshold;
  } lhm_cfg_t;

  typedef struct packed {
    logic       stopped;
    logic       suspended;
    logic [1:0] event_res;
  } lhm_result_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

  // count >= limit with both sides widened to a common width
  function automatic logic count_ge(input logic [COUNT_WIDTH-1:0] cnt,
                                    input logic [7:0] lim);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = CMP_W'(cnt);
    b = CMP_W'(lim);
    count_ge = (a >= b);
  endfunction

endpackage

@@ hdl/lhm_cfg_regs.sv @@
// Configuration register bank of the link health monitor.
module lhm_cfg_regs
  import lhm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output lhm_cfg_t              cfg
);

  lhm_cfg_t cfg_r;
  lhm_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DOWN_MODE:    cfg_nxt.down_mode    = down_mode_t'(cfg_wdata[1:0]);
        REG_UP_MODE:      cfg_nxt.up_mode      = cfg_wdata[0];
        REG_RETRY_LIMIT:  cfg_nxt.retry_limit  = cfg_wdata[7:0];
        REG_UP_THRESHOLD: cfg_nxt.up_threshold = cfg_wdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.down_mode    <= DOWN_STOP;
      cfg_r.up_mode      <= UP_POST;
      cfg_r.retry_limit  <= 8'd3;
      cfg_r.up_threshold <= 8'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/lhm_core.sv @@
// Per-tick state update of the link health monitor.
module lhm_core
  import lhm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        alive,
  input  lhm_cfg_t    cfg,
  output lhm_result_t result
);
  `include "link_health_monitor_unit_assert.svh"

  logic                   last_alive_r, last_alive_nxt;
  logic                   retrying_r, retrying_nxt;
  logic [COUNT_WIDTH-1:0] retry_count_r, retry_count_nxt;
  logic                   suspend_flag_r, suspend_flag_nxt;
  logic                   stop_flag_r, stop_flag_nxt;
  logic [COUNT_WIDTH-1:0] up_count_r, up_count_nxt;
  logic [1:0]             event_nxt;

  always_comb begin
    last_alive_nxt   = last_alive_r;
    retrying_nxt     = retrying_r;
    retry_count_nxt  = retry_count_r;
    suspend_flag_nxt = suspend_flag_r;
    stop_flag_nxt    = stop_flag_r;
    up_count_nxt     = up_count_r;
    event_nxt        = EVT_NONE;

    if (stop_flag_r) begin
      // stopped: frozen
    end else if (suspend_flag_r) begin
      if (!alive) begin
        up_count_nxt = '0;
      end else begin
        up_count_nxt = sat_inc(up_count_r);
        if (count_ge(up_count_nxt, cfg.up_threshold)) begin
          suspend_flag_nxt = 1'b0;
        end
      end
    end else begin
      if (last_alive_r != alive) begin
        if (!alive) begin
          case (cfg.down_mode)
            DOWN_STOP:    stop_flag_nxt = 1'b1;
            DOWN_SUSPEND: begin
              suspend_flag_nxt = 1'b1;
              up_count_nxt     = '0;
            end
            DOWN_POST:    event_nxt = EVT_DOWN;
            default:      retrying_nxt = 1'b1;
          endcase
        end else begin
          if (cfg.up_mode == UP_POST) begin
            event_nxt = EVT_UP;
          end
          retrying_nxt    = 1'b0;
          retry_count_nxt = '0;
        end
      end
      if (retrying_nxt) begin
        retry_count_nxt = sat_inc(retry_count_nxt);
        if (count_ge(retry_count_nxt, cfg.retry_limit)) begin
          event_nxt        = EVT_DOWN;
          suspend_flag_nxt = 1'b1;
          up_count_nxt     = '0;
        end
      end
      last_alive_nxt = alive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_alive_r   <= 1'b0;
      retrying_r     <= 1'b0;
      retry_count_r  <= '0;
      suspend_flag_r <= 1'b0;
      stop_flag_r    <= 1'b0;
      up_count_r     <= '0;
    end else if (accept) begin
      last_alive_r   <= last_alive_nxt;
      retrying_r     <= retrying_nxt;
      retry_count_r  <= retry_count_nxt;
      suspend_flag_r <= suspend_flag_nxt;
      stop_flag_r    <= stop_flag_nxt;
      up_count_r     <= up_count_nxt;
    end
  end

  assign result.event_res = event_nxt;
  assign result.suspended = suspend_flag_nxt;
  assign result.stopped   = stop_flag_nxt;

  `LHM_ASSERT(a_stop_sticks, clk, rst_n, stop_flag_r |=> stop_flag_r, "stop flag cleared")
  `LHM_NEVER(a_stop_quiet, clk, rst_n, stop_flag_r && (event_nxt != EVT_NONE), "event while stopped")

endmodule

@@ hdl/lhm_out_skid.sv @@
// Two-entry result buffer between the update logic and the result channel.
module lhm_out_skid
  import lhm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lhm_result_t push_data,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output lhm_result_t out_data
);
  `include "link_health_monitor_unit_assert.svh"

  logic        main_v_r, main_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  lhm_result_t main_d_r, main_d_nxt;
  lhm_result_t skid_d_r, skid_d_nxt;
  logic        pop;

  assign pop      = main_v_r && out_ready;
  assign can_push = !skid_v_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_d_nxt = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  `LHM_ASSERT(a_skid_needs_main, clk, rst_n, skid_v_r |-> main_v_r, "skid full, main empty")
  `LHM_NEVER(a_no_push_full, clk, rst_n, skid_v_r && push, "push into full buffer")
  `LHM_ASSERT(a_skid_drain, clk, rst_n, (skid_v_r && pop) |=> (main_v_r && !skid_v_r), "skid drain lost")

endmodule

@@ hdl/link_health_monitor_unit.sv @@
// Top level of the link health monitor: config bank, tick update, result buffer.
//
// Link health monitor. Each input beat is one probe tick (in_tdata[0] = alive).
// Every accepted beat yields exactly one result beat giving the posted event
// (none, link down, link up) and the suspended and stopped flags after the tick.
// Throughput is one beat per clock while in_tready is high: the flag and counter
// update is a single combinational step, and the monitor state registers load on
// the accepting edge, where the result is also written into the output buffer.
// Results sit in a two-entry buffer, so in_tready stays high while one result waits
// and drops only when both entries are held by a stalled result channel. The user must
// write configuration (down_mode, up_mode, retry_limit, up_threshold at indexes 0..3)
// through cfg_we/cfg_index/cfg_wdata while the block is idle; it does not enforce this.
module link_health_monitor_unit
  import lhm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // probe ticks
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] alive, [7:1] zero
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [1:0] event_res, [2] suspended, [3] stopped
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lhm_cfg_t    cfg;
  lhm_result_t tick_result;
  lhm_result_t out_result;
  logic        in_beat;
  logic        can_push;

  // beat accepted whenever the buffer has a free entry
  assign in_tready = can_push;
  assign in_beat   = in_tvalid && in_tready;

  lhm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lhm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_beat),
    .alive  (in_tdata[0]),
    .cfg    (cfg),
    .result (tick_result)
  );

  lhm_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_beat),
    .push_data (tick_result),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  // pack result fields, lowest first, zero filled
  assign out_tdata = {4'b0000, out_result.stopped, out_result.suspended,
                      out_result.event_res};

endmodule
